/* rtl/sfr_pkg.sv */
// sfr_pkg: shared types and constants of the stream find-and-replace block
// payload structs, register indexes, controller states, controller/datapath links
// no dependencies
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int STR_WORDS  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_W0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_W1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_W2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_W0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_W1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_W2  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              run_last;
        logic              stream_end;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT,
        ST_MARK
    } t_state;

    typedef struct packed {
        logic push;
        logic eval;
        logic emit;
        logic mark;
    } t_dp_cmd;

    typedef struct packed {
        logic none;
        logic last;
        logic end_flag;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/sfr_ctrl.sv */
// sfr_ctrl: request sequencer of the stream find-and-replace block
// takes one request, has the datapath evaluate it, then steps out its results
// depends on sfr_pkg
module sfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sfr_pkg::t_dp_stat i_stat,
    output sfr_pkg::t_dp_cmd  o_cmd
);

    sfr_pkg::t_state r_state;
    sfr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sfr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sfr_pkg::ST_EVAL;
                end
            end
            sfr_pkg::ST_EVAL: begin
                if (!i_stat.none) begin
                    n_state = sfr_pkg::ST_EMIT;
                end else if (i_stat.end_flag) begin
                    n_state = sfr_pkg::ST_MARK;
                end else begin
                    n_state = sfr_pkg::ST_IDLE;
                end
            end
            sfr_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.last) begin
                    n_state = sfr_pkg::ST_IDLE;
                end
            end
            sfr_pkg::ST_MARK: begin
                if (i_stat.out_free) begin
                    n_state = sfr_pkg::ST_IDLE;
                end
            end
            default: n_state = sfr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            sfr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.push = i_in_valid;
            end
            sfr_pkg::ST_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            sfr_pkg::ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            sfr_pkg::ST_MARK: begin
                o_cmd.mark = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/sfr_datapath.sv */
// sfr_datapath: configuration registers, pending-byte window, match logic
// and the output register of the stream find-and-replace block
// depends on sfr_pkg
module sfr_datapath #(
    parameter int PATTERN_MAX = 24,
    parameter int REPLACE_MAX = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  sfr_pkg::t_in_item                   i_in_data,
    input  sfr_pkg::t_dp_cmd                    i_cmd,
    output sfr_pkg::t_dp_stat                   o_stat,
    output logic                                o_out_valid,
    output sfr_pkg::t_out_item                  o_out_data,
    input  logic                                i_out_stall
);

    localparam int CW   = $clog2(PATTERN_MAX + 1);
    localparam int MAXN = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
    localparam int MW   = $clog2(MAXN + 1);
    localparam int RIW  = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
    localparam int LW   = sfr_pkg::LEN_W;

    logic [sfr_pkg::CFG_DATA_W-1:0] r_pword [sfr_pkg::STR_WORDS];
    logic [sfr_pkg::CFG_DATA_W-1:0] r_rword [sfr_pkg::STR_WORDS];
    logic [LW-1:0]                  r_plen;
    logic [LW-1:0]                  r_rlen;

    logic [sfr_pkg::BYTE_W-1:0] r_win [PATTERN_MAX];
    logic [CW-1:0]              r_count;
    logic                       r_end;
    logic                       r_rep;
    logic [MW-1:0]              r_rem;
    logic [RIW-1:0]             r_ridx;

    logic               r_ov;
    sfr_pkg::t_out_item r_out;

    logic [sfr_pkg::BYTE_W-1:0] pbytes [PATTERN_MAX];
    logic [sfr_pkg::BYTE_W-1:0] rbytes [REPLACE_MAX];
    logic [LW-1:0]              c5;
    logic [LW-1:0]              plen5;
    logic [LW-1:0]              rlen5;
    logic [LW-1:0]              pops5;
    logic [LW-1:0]              n5;
    logic                       hit;
    logic                       all_eq;
    logic                       last;
    logic                       out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < sfr_pkg::STR_WORDS; w++) begin
                r_pword[w] <= '0;
                r_rword[w] <= '0;
            end
            r_plen <= '0;
            r_rlen <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                sfr_pkg::CFG_PAT_W0:  r_pword[0] <= i_cfg_wdata;
                sfr_pkg::CFG_PAT_W1:  r_pword[1] <= i_cfg_wdata;
                sfr_pkg::CFG_PAT_W2:  r_pword[2] <= i_cfg_wdata;
                sfr_pkg::CFG_PAT_LEN: r_plen     <= i_cfg_wdata[LW-1:0];
                sfr_pkg::CFG_REP_W0:  r_rword[0] <= i_cfg_wdata;
                sfr_pkg::CFG_REP_W1:  r_rword[1] <= i_cfg_wdata;
                sfr_pkg::CFG_REP_W2:  r_rword[2] <= i_cfg_wdata;
                sfr_pkg::CFG_REP_LEN: r_rlen     <= i_cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // byte views of the strings, byte k in word k/8
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pbytes[k] = r_pword[k >> 3][8 * (k & 7) +: sfr_pkg::BYTE_W];
        end
        for (int k = 0; k < REPLACE_MAX; k++) begin
            rbytes[k] = r_rword[k >> 3][8 * (k & 7) +: sfr_pkg::BYTE_W];
        end
    end

    // evaluation of the window after a push
    always_comb begin
        c5    = LW'(r_count);
        plen5 = (r_plen > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : r_plen;
        rlen5 = (r_rlen > LW'(REPLACE_MAX)) ? LW'(REPLACE_MAX) : r_rlen;

        all_eq = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if ((LW'(k) < plen5) && (r_win[k] != pbytes[k])) begin
                all_eq = 1'b0;
            end
        end
        hit = (c5 == plen5) && (plen5 != '0) && all_eq;

        if (r_end) begin
            pops5 = c5;
        end else if (c5 > plen5) begin
            pops5 = ((c5 - plen5) >= LW'(2)) ? LW'(2) : (c5 - plen5);
        end else if (c5 == plen5) begin
            pops5 = LW'(1);
        end else begin
            pops5 = '0;
        end

        n5 = hit ? rlen5 : pops5;
    end

    assign last     = (r_rem == MW'(1));
    assign out_free = !r_ov || !i_out_stall;

    assign o_stat.none     = (n5 == '0);
    assign o_stat.last     = last;
    assign o_stat.end_flag = r_end;
    assign o_stat.out_free = out_free;

    // window shift line
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                if (LW'(k) == c5) begin
                    r_win[k] <= i_in_data.in_byte;
                end
            end
        end else if (i_cmd.emit && !r_rep) begin
            for (int k = 0; k < PATTERN_MAX - 1; k++) begin
                r_win[k] <= r_win[k + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.eval && hit) begin
            r_count <= '0;
        end else if (i_cmd.emit && !r_rep) begin
            r_count <= r_count - CW'(1);
        end
    end

    // per-request sequencing data
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_end <= i_in_data.in_end;
        end
        if (i_cmd.eval) begin
            r_rep  <= hit;
            r_rem  <= MW'(n5);
            r_ridx <= '0;
        end else if (i_cmd.emit) begin
            r_rem  <= r_rem - MW'(1);
            r_ridx <= r_ridx + RIW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit || i_cmd.mark) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte   <= r_rep ? rbytes[r_ridx] : r_win[0];
            r_out.has_byte   <= 1'b1;
            r_out.run_last   <= last;
            r_out.stream_end <= r_end && last;
        end else if (i_cmd.mark) begin
            r_out.out_byte   <= '0;
            r_out.has_byte   <= 1'b0;
            r_out.run_last   <= 1'b1;
            r_out.stream_end <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

/* rtl/stream_find_replace.sv */
// stream_find_replace: top level of the streaming find-and-replace block
// joins the sequencer sfr_ctrl and the datapath sfr_datapath
// depends on sfr_pkg, sfr_ctrl and sfr_datapath
//
// Input channel: one stream byte per request with an end-of-stream flag.
// Output channel: one byte per result, flagged with has_byte, run_last on the
// last result caused by an input byte and stream_end on the final one.
// An ending byte that causes no output gives one empty marker result.
// Configuration: plain write port, pattern and replacement words and lengths, to be
// written only while the block is idle; the block itself does not enforce this.
// Sequencing: the sequencer takes an input byte, has the datapath evaluate it,
// then steps the results it causes one at a time through the single output
// register. A byte that only enters the window causes no result, a match emits
// the replacement bytes and an end of stream the bytes left (or an empty end
// marker).
// Results leave through a register; the first one is valid after the request has
// been taken and evaluated, and the rest follow one per cycle. While the receiver
// stalls, the held result stays put and the block waits; input is stalled
// whenever a request is still in work.
// Reset (synchronous, active low) clears the state, configuration, byte count and output valid and empties the window.
module stream_find_replace #(
    parameter int PATTERN_MAX = 24,
    parameter int REPLACE_MAX = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sfr_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sfr_pkg::t_out_item             o_out_data
);

    sfr_pkg::t_dp_cmd  cmd;
    sfr_pkg::t_dp_stat stat;

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sfr_datapath #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

/* rtl/sfr_checker.sv */
// sfr_checker: port-level checks of the stream find-and-replace block
// bound to stream_find_replace; depends on sfr_pkg
module sfr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  sfr_pkg::t_out_item             o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_byte |->
            o_out_data.run_last && o_out_data.stream_end && (o_out_data.out_byte == '0))
        else $error("malformed empty end marker");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stream_end |-> o_out_data.run_last)
        else $error("stream end without run end");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in work");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_chk (.*);
